FILE: design/mafr_pkg.sv
// shared types, constants and helper functions for the modbus angle frame receiver
// no dependencies; used by every other design file through scoped names
package mafr_pkg;

   // frame layout and header codes
   localparam int          DATA_BYTES     = 6;
   localparam logic [7:0]  HDR_FUNC       = 8'h03;
   localparam logic [7:0]  HDR_COUNT      = 8'h06;
   localparam logic [7:0]  SLAVE_ID_RESET = 8'd80;
   localparam logic [2:0]  CRC_LOW_POS    = 3'd6;

   // crc-16/modbus, reflected
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;

   // angle scale: raw / 32768 * 180 with 15 fraction bits is raw * 180
   localparam logic signed [23:0] ANGLE_MUL = 24'sd180;

   // parser state, one-hot
   typedef enum logic [3:0] {
      ST_HUNT  = 4'b0001,
      ST_FUNC  = 4'b0010,
      ST_COUNT = 4'b0100,
      ST_BODY  = 4'b1000
   } parse_state_type;

   // end-of-frame summary from the parser to the result stage
   typedef struct packed {
      logic                             done;
      logic                             ok;
      logic [DATA_BYTES-1:0][7:0]       data;
   } frame_result_type;

   // one byte through the crc, bit by bit
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // big-endian signed word scaled to degrees
   function automatic logic signed [23:0] angle_of(input logic [7:0] hi, input logic [7:0] lo);
      logic signed [15:0] word;
      logic signed [23:0] raw;
      word = signed'({hi, lo});
      raw  = 24'(word);
      return 24'(raw * ANGLE_MUL);
   endfunction

endpackage

FILE: design/mafr_frame_parser.sv
// frame parser: header hunt, running crc, data byte store, crc verdict on the last byte
// depends on mafr_pkg
module mafr_frame_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 rx_byte,
   input  logic [7:0]                 slave_id,
   output mafr_pkg::frame_result_type frame
);

   mafr_pkg::parse_state_type state_ff, state_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [mafr_pkg::DATA_BYTES-1:0][7:0] data_ff, data_in;
   logic        last_beat;

   // next state of the header / body walk
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      data_in    = data_ff;
      last_beat  = 1'b0;
      unique case (state_ff)
         mafr_pkg::ST_HUNT: begin
            if (rx_byte == slave_id) begin
               crc_in   = mafr_pkg::crc_feed(mafr_pkg::CRC_INIT, rx_byte);
               state_in = mafr_pkg::ST_FUNC;
            end
         end
         mafr_pkg::ST_FUNC: begin
            if (rx_byte == mafr_pkg::HDR_FUNC) begin
               crc_in   = mafr_pkg::crc_feed(crc_ff, rx_byte);
               state_in = mafr_pkg::ST_COUNT;
            end else if (rx_byte == slave_id) begin
               // repeated id restarts the frame here
               crc_in   = mafr_pkg::crc_feed(mafr_pkg::CRC_INIT, rx_byte);
            end else begin
               state_in = mafr_pkg::ST_HUNT;
            end
         end
         mafr_pkg::ST_COUNT: begin
            if (rx_byte == mafr_pkg::HDR_COUNT) begin
               crc_in   = mafr_pkg::crc_feed(crc_ff, rx_byte);
               idx_in   = '0;
               state_in = mafr_pkg::ST_BODY;
            end else begin
               state_in = mafr_pkg::ST_HUNT;
            end
         end
         mafr_pkg::ST_BODY: begin
            if (idx_ff < mafr_pkg::CRC_LOW_POS) begin
               data_in[idx_ff] = rx_byte;
               crc_in          = mafr_pkg::crc_feed(crc_ff, rx_byte);
               idx_in          = idx_ff + 3'd1;
            end else if (idx_ff == mafr_pkg::CRC_LOW_POS) begin
               crc_low_in = rx_byte;
               idx_in     = idx_ff + 3'd1;
            end else begin
               // crc high byte closes the frame
               last_beat = 1'b1;
               state_in  = mafr_pkg::ST_HUNT;
               idx_in    = '0;
               crc_in    = mafr_pkg::CRC_INIT;
            end
         end
         default: begin
            state_in = mafr_pkg::ST_HUNT;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mafr_pkg::ST_HUNT;
         idx_ff   <= '0;
         crc_ff   <= mafr_pkg::CRC_INIT;
      end else if (step) begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
      end
   end

   // payload bytes and received crc low byte
   always_ff @(posedge clock) begin
      if (step) begin
         data_ff    <= data_in;
         crc_low_ff <= crc_low_in;
      end
   end

   // frame summary, valid in the beat that carries the crc high byte
   assign frame.done = step && last_beat;
   assign frame.ok   = (crc_low_ff == crc_ff[7:0]) && (rx_byte == crc_ff[15:8]);
   assign frame.data = data_ff;

   // a closed frame always leaves the parser hunting with a fresh crc
   assert property (@(posedge clock) disable iff (reset)
      frame.done |=> (state_ff == mafr_pkg::ST_HUNT) && (crc_ff == mafr_pkg::CRC_INIT))
      else $error("parser did not return to hunting after a frame");

   // data bytes advance the body position one at a time
   assert property (@(posedge clock) disable iff (reset)
      step && (state_ff == mafr_pkg::ST_BODY) && (idx_ff < mafr_pkg::CRC_LOW_POS)
      |=> idx_ff == $past(idx_ff) + 3'd1)
      else $error("body position skipped a byte");

endmodule

FILE: design/mafr_result_stage.sv
// result register: scales the three angles and holds the result beat for the consumer
// depends on mafr_pkg
module mafr_result_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  mafr_pkg::frame_result_type frame,
   output logic                       out_free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_crc_ok,
   output logic signed [23:0]         rsp_roll_angle,
   output logic signed [23:0]         rsp_pitch_angle,
   output logic signed [23:0]         rsp_yaw_angle
);

   logic                valid_ff, valid_in;
   logic                ok_ff;
   logic signed [23:0]  roll_ff, pitch_ff, yaw_ff;
   logic signed [23:0]  roll_in, pitch_in, yaw_in;
   logic                load;

   // register can take a beat when empty or being drained
   assign out_free = !valid_ff || !rsp_stall;
   assign load     = frame.done;

   // angles are zero on a crc mismatch
   always_comb begin
      roll_in  = '0;
      pitch_in = '0;
      yaw_in   = '0;
      if (frame.ok) begin
         roll_in  = mafr_pkg::angle_of(frame.data[0], frame.data[1]);
         pitch_in = mafr_pkg::angle_of(frame.data[2], frame.data[3]);
         yaw_in   = mafr_pkg::angle_of(frame.data[4], frame.data[5]);
      end
   end

   // valid flag
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload only moves on a load
   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff    <= frame.ok;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_crc_ok      = ok_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

   // a failed frame shows up with all angles cleared
   assert property (@(posedge clock) disable iff (reset)
      load && !frame.ok |=> valid_ff && !ok_ff && (roll_ff == '0) && (pitch_ff == '0)
                            && (yaw_ff == '0))
      else $error("bad crc frame carried nonzero angles");

endmodule

FILE: design/modbus_angle_frame_receiver_unit.sv
// top level of the modbus angle frame receiver: input register, slave id register,
// parser and result stage; depends on mafr_pkg, mafr_frame_parser, mafr_result_stage
//
// Usage:
//   req_ channel: one received serial byte per beat (req_rx_byte). A beat is taken at a
//   rising edge with req_valid high and req_stall low.
//   rsp_ channel: one beat per complete 11-byte read response (slave id, 0x03, 0x06, six
//   data bytes, crc low, crc high). rsp_crc_ok gives the crc verdict; the three angles are
//   signed degrees with 15 fraction bits and read as zero when the crc fails. Bytes that do
//   not close a frame give no beat.
//   csr_ channel: writes the expected slave id (csr_slave_id); csr_ready is always high.
//   Write it only while no frame byte is in flight.
// Timing:
//   one byte per cycle sustained while rsp_stall stays low; the byte-wise crc update and the
//   header compare both sit between the input register and the result register. A closing
//   byte is held in the input register, and its result beat is then held in the result register.
// Reset:
//   synchronous, clears the parser to hunting, the crc to 0xFFFF, both registers to empty
//   and the slave id to 80.
// Stall:
//   while rsp_stall holds a result beat, the input register keeps its byte and req_stall
//   goes high once that register is full; no byte or result is dropped.
module modbus_angle_frame_receiver_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_crc_ok,
   output logic signed [23:0] rsp_roll_angle,
   output logic signed [23:0] rsp_pitch_angle,
   output logic signed [23:0] rsp_yaw_angle,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_slave_id
);

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic [7:0]                 slave_id_ff;
   logic                       out_free;
   logic                       step;
   logic                       req_take;
   mafr_pkg::frame_result_type frame;

   // slave id register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff <= mafr_pkg::SLAVE_ID_RESET;
      end else if (csr_valid && csr_ready) begin
         slave_id_ff <= csr_slave_id;
      end
   end

   // input register, drained whenever the result side can take a beat
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   mafr_frame_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_byte  (in_byte_ff),
      .slave_id (slave_id_ff),
      .frame    (frame)
   );

   mafr_result_stage u_result (
      .clock           (clock),
      .reset           (reset),
      .frame           (frame),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_crc_ok      (rsp_crc_ok),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle)
   );

   // a frame close always lands in the result register on the next edge
   assert property (@(posedge clock) disable iff (reset)
      frame.done |=> rsp_valid)
      else $error("closed frame produced no result beat");

endmodule
